### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the RTL. Synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: assertion failed");

`else

// synthesis: no checks
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

### hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Widths, token codes, scanner mode codes and lookup functions for the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    // widths
    localparam int POS_BITS     = 20;
    localparam int KW_MAX_CHARS = 6;
    localparam int PREFIX_BITS  = 8 * KW_MAX_CHARS;
    localparam int LEN_BITS     = $clog2(KW_MAX_CHARS + 2);
    localparam int TYPE_BITS    = 6;
    localparam int OFS_BITS     = 20;
    localparam int OUT_FIELD_BITS = TYPE_BITS + 3 * OFS_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_DATA_BITS   = 8;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // scanner modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_NUMBER  = 3'd2;
    localparam logic [2:0] M_IDENT   = 3'd3;
    localparam logic [2:0] M_BANG    = 3'd4;
    localparam logic [2:0] M_ASSIGN  = 3'd5;
    localparam logic [2:0] M_LT      = 3'd6;
    localparam logic [2:0] M_GT      = 3'd7;

    // token codes
    localparam logic [TYPE_BITS-1:0] TOK_EOF       = 6'd0;
    localparam logic [TYPE_BITS-1:0] TOK_UNKNOWN   = 6'd1;
    localparam logic [TYPE_BITS-1:0] TOK_IDENT     = 6'd2;
    localparam logic [TYPE_BITS-1:0] TOK_NUMBER    = 6'd3;
    localparam logic [TYPE_BITS-1:0] TOK_ASSIGN    = 6'd4;
    localparam logic [TYPE_BITS-1:0] TOK_PLUS      = 6'd5;
    localparam logic [TYPE_BITS-1:0] TOK_MINUS     = 6'd6;
    localparam logic [TYPE_BITS-1:0] TOK_BANG      = 6'd7;
    localparam logic [TYPE_BITS-1:0] TOK_ASTERISK  = 6'd8;
    localparam logic [TYPE_BITS-1:0] TOK_SLASH     = 6'd9;
    localparam logic [TYPE_BITS-1:0] TOK_EQ        = 6'd10;
    localparam logic [TYPE_BITS-1:0] TOK_NOTEQ     = 6'd11;
    localparam logic [TYPE_BITS-1:0] TOK_LT        = 6'd12;
    localparam logic [TYPE_BITS-1:0] TOK_LTEQ      = 6'd13;
    localparam logic [TYPE_BITS-1:0] TOK_GT        = 6'd14;
    localparam logic [TYPE_BITS-1:0] TOK_GTEQ      = 6'd15;
    localparam logic [TYPE_BITS-1:0] TOK_COMMA     = 6'd16;
    localparam logic [TYPE_BITS-1:0] TOK_SEMICOLON = 6'd17;
    localparam logic [TYPE_BITS-1:0] TOK_COLON     = 6'd18;
    localparam logic [TYPE_BITS-1:0] TOK_LPAREN    = 6'd19;
    localparam logic [TYPE_BITS-1:0] TOK_RPAREN    = 6'd20;
    localparam logic [TYPE_BITS-1:0] TOK_LBRACE    = 6'd21;
    localparam logic [TYPE_BITS-1:0] TOK_RBRACE    = 6'd22;
    localparam logic [TYPE_BITS-1:0] TOK_LBRACKET  = 6'd23;
    localparam logic [TYPE_BITS-1:0] TOK_RBRACKET  = 6'd24;
    localparam logic [TYPE_BITS-1:0] TOK_KW_NULL   = 6'd25;
    localparam logic [TYPE_BITS-1:0] TOK_KW_TRUE   = 6'd26;
    localparam logic [TYPE_BITS-1:0] TOK_KW_FALSE  = 6'd27;
    localparam logic [TYPE_BITS-1:0] TOK_KW_AND    = 6'd28;
    localparam logic [TYPE_BITS-1:0] TOK_KW_OR     = 6'd29;
    localparam logic [TYPE_BITS-1:0] TOK_KW_IF     = 6'd30;
    localparam logic [TYPE_BITS-1:0] TOK_KW_ELSE   = 6'd31;
    localparam logic [TYPE_BITS-1:0] TOK_KW_WHILE  = 6'd32;
    localparam logic [TYPE_BITS-1:0] TOK_KW_FOR    = 6'd33;
    localparam logic [TYPE_BITS-1:0] TOK_KW_LET    = 6'd34;
    localparam logic [TYPE_BITS-1:0] TOK_KW_MUT    = 6'd35;
    localparam logic [TYPE_BITS-1:0] TOK_KW_FUNC   = 6'd36;
    localparam logic [TYPE_BITS-1:0] TOK_KW_RETURN = 6'd37;

    // keyword spellings, first character in the lowest byte
    localparam logic [PREFIX_BITS-1:0] KW_NULL   = PREFIX_BITS'("llun");
    localparam logic [PREFIX_BITS-1:0] KW_TRUE   = PREFIX_BITS'("eurt");
    localparam logic [PREFIX_BITS-1:0] KW_FALSE  = PREFIX_BITS'("eslaf");
    localparam logic [PREFIX_BITS-1:0] KW_AND    = PREFIX_BITS'("dna");
    localparam logic [PREFIX_BITS-1:0] KW_OR     = PREFIX_BITS'("ro");
    localparam logic [PREFIX_BITS-1:0] KW_IF     = PREFIX_BITS'("fi");
    localparam logic [PREFIX_BITS-1:0] KW_ELSE   = PREFIX_BITS'("esle");
    localparam logic [PREFIX_BITS-1:0] KW_WHILE  = PREFIX_BITS'("elihw");
    localparam logic [PREFIX_BITS-1:0] KW_FOR    = PREFIX_BITS'("rof");
    localparam logic [PREFIX_BITS-1:0] KW_LET    = PREFIX_BITS'("tel");
    localparam logic [PREFIX_BITS-1:0] KW_MUT    = PREFIX_BITS'("tum");
    localparam logic [PREFIX_BITS-1:0] KW_FUNC   = PREFIX_BITS'("cnuf");
    localparam logic [PREFIX_BITS-1:0] KW_RETURN = PREFIX_BITS'("nruter");

    // one result beat
    typedef struct packed {
        logic [TYPE_BITS-1:0] token_type;
        logic [OFS_BITS-1:0]  start_offset;
        logic [OFS_BITS-1:0]  end_offset;
        logic [OFS_BITS-1:0]  token_line;
        logic                 last_of_run;
    } token_t;

    // saturating increment of a position or line counter
    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_BITS'(1);
    endfunction

    // position to output offset width
    function automatic logic [OFS_BITS-1:0] to_ofs(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OFS_BITS-1:0];
    endfunction

    // identifier or keyword; unused prefix bytes are zero and word chars are not
    function automatic logic [TYPE_BITS-1:0] kw_type(input logic [PREFIX_BITS-1:0] prefix,
                                                     input logic [LEN_BITS-1:0] len);
        logic [TYPE_BITS-1:0] t;
        t = TOK_IDENT;
        if (len <= LEN_BITS'(KW_MAX_CHARS))
        begin
            unique case (prefix)
                KW_NULL:   t = TOK_KW_NULL;
                KW_TRUE:   t = TOK_KW_TRUE;
                KW_FALSE:  t = TOK_KW_FALSE;
                KW_AND:    t = TOK_KW_AND;
                KW_OR:     t = TOK_KW_OR;
                KW_IF:     t = TOK_KW_IF;
                KW_ELSE:   t = TOK_KW_ELSE;
                KW_WHILE:  t = TOK_KW_WHILE;
                KW_FOR:    t = TOK_KW_FOR;
                KW_LET:    t = TOK_KW_LET;
                KW_MUT:    t = TOK_KW_MUT;
                KW_FUNC:   t = TOK_KW_FUNC;
                KW_RETURN: t = TOK_KW_RETURN;
                default:   t = TOK_IDENT;
            endcase
        end
        return t;
    endfunction

    // one-character tokens that never extend
    function automatic logic [TYPE_BITS-1:0] single_type(input logic [7:0] c);
        logic [TYPE_BITS-1:0] t;
        unique case (c)
            "(":     t = TOK_LPAREN;
            ")":     t = TOK_RPAREN;
            "{":     t = TOK_LBRACE;
            "}":     t = TOK_RBRACE;
            "[":     t = TOK_LBRACKET;
            "]":     t = TOK_RBRACKET;
            ",":     t = TOK_COMMA;
            ";":     t = TOK_SEMICOLON;
            ":":     t = TOK_COLON;
            "-":     t = TOK_MINUS;
            "+":     t = TOK_PLUS;
            "/":     t = TOK_SLASH;
            "*":     t = TOK_ASTERISK;
            default: t = TOK_UNKNOWN;
        endcase
        return t;
    endfunction

    // operators that may take a trailing '='
    function automatic logic [TYPE_BITS-1:0] pair_type(input logic [2:0] mode,
                                                       input logic with_eq);
        logic [TYPE_BITS-1:0] t;
        unique case (mode)
            M_BANG:   t = with_eq ? TOK_NOTEQ : TOK_BANG;
            M_ASSIGN: t = with_eq ? TOK_EQ    : TOK_ASSIGN;
            M_LT:     t = with_eq ? TOK_LTEQ  : TOK_LT;
            default:  t = with_eq ? TOK_GTEQ  : TOK_GT;
        endcase
        return t;
    endfunction

endpackage

### hdl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-stream lexer: numbers, identifiers with keywords, operators,
// brackets, delimiters, comments and line counting.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one source byte per beat in tdata[7:0]; tlast set means
//   end of text (no byte). A zero byte also acts as end of text.
//   m_axis carries one token per beat: type, start and end offset and the
//   line the token began on; tlast marks the last token caused by one
//   input beat (an input beat gives zero, one or two tokens).
//   End of text flushes any open token and then gives an EOF token with
//   start = end = current position; counters are kept afterwards.
// Timing:
//   the scanner state update and the token decode are combinational; a token
//   is queued with the input beat that closes it and is offered on m_axis
//   after any tokens queued before it. One input beat is taken every cycle
//   while the queue has room; a two-token input beat costs two output beats.
//   Tokens go into a four-entry output queue; s_axis_tready is high while
//   the queue has room for two tokens, so a stalled receiver stops input
//   once three tokens wait, and the two tokens of one beat always fit.
// Reset:
//   scanner idle, position and line count zero, output queue empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module source_text_tokenizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [stt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // [7:0] char_byte
    input  logic                              s_axis_tlast,  // end_of_text
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] token_type, [25:6] start_offset, [45:26] end_offset,
    // [65:46] token_line, [71:66] zero
    output logic [stt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                              m_axis_tlast   // last_of_run
);
    import stt_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    // scanner state
    logic [2:0]             mode_reg, mode_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [POS_BITS-1:0]    tok_start_reg, tok_start_next;
    logic [POS_BITS-1:0]    tok_line_reg, tok_line_next;
    logic [POS_BITS-1:0]    line_reg, line_next;
    logic [PREFIX_BITS-1:0] prefix_reg, prefix_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;

    // output queue
    token_t                 fifo_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;

    // decode
    logic                   accept;
    logic                   pop;
    logic [7:0]             char_c;
    logic                   eot_c;
    logic                   digit_c, letter_c, is_eq, is_nl, is_space;
    logic                   is_pair_mode;
    logic                   extend_c;
    logic                   pair_eq_c;
    logic                   do_close;
    logic                   do_fresh;
    logic                   fresh_emit;
    logic [TYPE_BITS-1:0]   close_type;
    logic [POS_BITS-1:0]    pos_inc;
    logic [POS_BITS-1:0]    line_inc;
    token_t                 res_a, res_b;
    logic                   res_a_valid, res_b_valid;
    logic [1:0]             push_n;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    // byte classes
    assign char_c   = s_axis_tdata[7:0];
    assign eot_c    = s_axis_tlast || (char_c == 8'd0);
    assign digit_c  = (char_c >= "0") && (char_c <= "9");
    assign letter_c = ((char_c >= "a") && (char_c <= "z")) ||
                      ((char_c >= "A") && (char_c <= "Z")) || (char_c == "_");
    assign is_eq    = (char_c == "=");
    assign is_nl    = (char_c == 8'h0A);
    assign is_space = (char_c == " ") || (char_c == 8'h09) || (char_c == 8'h0D);

    assign pos_inc  = sat_inc(pos_reg);
    assign line_inc = sat_inc(line_reg);

    // token open / close decisions
    assign is_pair_mode = (mode_reg >= M_BANG);
    assign extend_c     = ((mode_reg == M_NUMBER) && digit_c) ||
                          ((mode_reg == M_IDENT) && (letter_c || digit_c));
    assign pair_eq_c    = !eot_c && is_pair_mode && is_eq;
    assign do_close     = eot_c ||
                          (((mode_reg == M_NUMBER) || (mode_reg == M_IDENT) || is_pair_mode)
                           && !extend_c && !pair_eq_c);
    assign do_fresh     = !eot_c && ((mode_reg == M_IDLE) || do_close);
    assign fresh_emit   = do_fresh && !is_nl && !is_space && !digit_c && !letter_c &&
                          (char_c != "#") && (char_c != "!") && !is_eq &&
                          (char_c != "<") && (char_c != ">");

    // type of the token being closed
    always_comb
    begin
        unique case (mode_reg)
            M_NUMBER: close_type = TOK_NUMBER;
            M_IDENT:  close_type = kw_type(prefix_reg, len_reg);
            default:  close_type = pair_type(mode_reg, 1'b0);
        endcase
    end

    // first result: closed token or two-character operator
    assign res_a_valid = (do_close && ((mode_reg == M_NUMBER) || (mode_reg == M_IDENT) ||
                                       is_pair_mode)) || pair_eq_c;
    always_comb
    begin
        res_a.token_type   = pair_eq_c ? pair_type(mode_reg, 1'b1) : close_type;
        res_a.start_offset = to_ofs(tok_start_reg);
        res_a.end_offset   = to_ofs(pair_eq_c ? pos_inc : pos_reg);
        res_a.token_line   = to_ofs(tok_line_reg);
        res_a.last_of_run  = !res_b_valid;
    end

    // second result: one-character token or end of text
    assign res_b_valid = eot_c || fresh_emit;
    always_comb
    begin
        res_b.token_type   = eot_c ? TOK_EOF : single_type(char_c);
        res_b.start_offset = to_ofs(pos_reg);
        res_b.end_offset   = to_ofs(eot_c ? pos_reg : pos_inc);
        res_b.token_line   = to_ofs(line_reg);
        res_b.last_of_run  = 1'b1;
    end

    // scanner state update
    always_comb
    begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        tok_start_next = tok_start_reg;
        tok_line_next  = tok_line_reg;
        line_next      = line_reg;
        prefix_next    = prefix_reg;
        len_next       = len_reg;
        if (accept)
        begin
            if (eot_c)
            begin
                mode_next = M_IDLE;
            end
            else
            begin
                pos_next = pos_inc;
                if (mode_reg == M_COMMENT)
                begin
                    if (is_nl)
                    begin
                        line_next = line_inc;
                        mode_next = M_IDLE;
                    end
                end
                else if (extend_c)
                begin
                    if (mode_reg == M_IDENT)
                    begin
                        for (int i = 0; i < KW_MAX_CHARS; i++)
                        begin
                            if (len_reg == LEN_BITS'(i))
                            begin
                                prefix_next[8*i +: 8] = char_c;
                            end
                        end
                        if (len_reg <= LEN_BITS'(KW_MAX_CHARS))
                        begin
                            len_next = len_reg + LEN_BITS'(1);
                        end
                    end
                end
                else if (pair_eq_c)
                begin
                    mode_next = M_IDLE;
                end
                else if (do_fresh)
                begin
                    tok_start_next = pos_reg;
                    tok_line_next  = line_reg;
                    mode_next      = M_IDLE;
                    priority if (is_nl)
                    begin
                        line_next = line_inc;
                    end
                    else if (is_space)
                    begin
                        mode_next = M_IDLE;
                    end
                    else if (char_c == "#")
                    begin
                        mode_next = M_COMMENT;
                    end
                    else if (digit_c)
                    begin
                        mode_next = M_NUMBER;
                    end
                    else if (letter_c)
                    begin
                        mode_next   = M_IDENT;
                        prefix_next = PREFIX_BITS'(char_c);
                        len_next    = LEN_BITS'(1);
                    end
                    else if (char_c == "!")
                    begin
                        mode_next = M_BANG;
                    end
                    else if (is_eq)
                    begin
                        mode_next = M_ASSIGN;
                    end
                    else if (char_c == "<")
                    begin
                        mode_next = M_LT;
                    end
                    else if (char_c == ">")
                    begin
                        mode_next = M_GT;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                    end
                end
            end
        end
    end

    // queue pointers and fill level
    assign push_n = accept ? ({1'b0, res_a_valid} + {1'b0, res_b_valid}) : 2'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(push_n) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            pos_reg       <= '0;
            tok_start_reg <= '0;
            tok_line_reg  <= '0;
            line_reg      <= '0;
            prefix_reg    <= '0;
            len_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            tok_start_reg <= tok_start_next;
            tok_line_reg  <= tok_line_next;
            line_reg      <= line_next;
            prefix_reg    <= prefix_next;
            len_reg       <= len_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (res_a_valid)
            begin
                fifo_reg[wr_ptr_reg] <= res_a;
            end
            if (res_b_valid)
            begin
                fifo_reg[wr_ptr_reg + PTR_BITS'(res_a_valid)] <= res_b;
            end
        end
    end

    // stream ports
    assign s_axis_tready = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = OUT_DATA_BITS'({fifo_reg[rd_ptr_reg].token_line,
                                           fifo_reg[rd_ptr_reg].end_offset,
                                           fifo_reg[rd_ptr_reg].start_offset,
                                           fifo_reg[rd_ptr_reg].token_type});
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg].last_of_run;

    // checks
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_BITS'(FIFO_DEPTH))
    `ASSERT_NEXT(a_eot_idle, clk, rst_n, accept && s_axis_tlast, mode_reg == M_IDLE)
    `ASSERT_NEXT(a_eot_result, clk, rst_n, accept && s_axis_tlast, m_axis_tvalid)
    `ASSERT_NEXT(a_pos_monotone, clk, rst_n, 1'b1, pos_reg >= $past(pos_reg))
    `ASSERT_NEXT(a_line_monotone, clk, rst_n, 1'b1, line_reg >= $past(line_reg))

endmodule
